// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the byte-code machine RTL.
// Every macro samples on clock and is disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define XBVM_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define XBVM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/xbvm_pkg.sv
// Shared types, constants and helpers of the byte-code machine core.
// No dependencies; every other RTL file but assert_macros.svh imports this package.
package xbvm_pkg;

   localparam int BYTE_W     = 8;
   localparam int PC_WIDTH   = 8;
   localparam int REG_IDX_W  = 2;
   localparam int NUM_REGS   = 1 << REG_IDX_W;
   localparam int MEM_ADDR_W = 8;
   localparam int MEM_DEPTH  = 1 << MEM_ADDR_W;

   localparam logic [BYTE_W-1:0] KEY_RESET = 8'h9B;

   // decoded opcodes
   localparam logic [BYTE_W-1:0] OP_SET   = 8'h01;
   localparam logic [BYTE_W-1:0] OP_ADD   = 8'h02;
   localparam logic [BYTE_W-1:0] OP_PRINT = 8'h03;
   localparam logic [BYTE_W-1:0] OP_LOAD  = 8'h04;
   localparam logic [BYTE_W-1:0] OP_STORE = 8'h05;
   localparam logic [BYTE_W-1:0] OP_CMP   = 8'h06;
   localparam logic [BYTE_W-1:0] OP_JMP   = 8'h07;
   localparam logic [BYTE_W-1:0] OP_JEQ   = 8'h08;
   localparam logic [BYTE_W-1:0] OP_JNE   = 8'h09;
   localparam logic [BYTE_W-1:0] OP_HALT  = 8'hFF;

   // transaction kinds
   localparam logic FUNC_MEM_WRITE = 1'b0;
   localparam logic FUNC_EXECUTE   = 1'b1;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_IDX_XOR_KEY = 1'b0;

   typedef struct packed {
      logic              func;
      logic [BYTE_W-1:0] code_byte0;
      logic [BYTE_W-1:0] code_byte1;
      logic [BYTE_W-1:0] code_byte2;
      logic [BYTE_W-1:0] code_byte3;
      logic [BYTE_W-1:0] data_addr;
      logic [BYTE_W-1:0] data_value;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0]        next_pc;
      logic                     print_valid;
      logic signed [BYTE_W-1:0] print_value;
      logic                     halted;
      logic                     illegal_op;
   } rsp_type;

   typedef struct packed {
      logic              func;
      logic [BYTE_W-1:0] op;
      logic [BYTE_W-1:0] a;
      logic [BYTE_W-1:0] b;
      logic [BYTE_W-1:0] c;
      logic [BYTE_W-1:0] data_addr;
      logic [BYTE_W-1:0] data_value;
   } dec_type;

   typedef struct packed {
      logic                  en;
      logic [MEM_ADDR_W-1:0] addr;
      logic [BYTE_W-1:0]     data;
   } mem_wr_type;

   function automatic logic [MEM_ADDR_W-1:0] mem_index(input logic [BYTE_W-1:0] v);
      return v[MEM_ADDR_W-1:0];
   endfunction

   function automatic logic [REG_IDX_W-1:0] reg_index(input logic [BYTE_W-1:0] v);
      return v[REG_IDX_W-1:0];
   endfunction

endpackage

// File: hw/rtl/xbvm_chan_if.sv
// Valid/ready channel interfaces for request and response transactions.
// Depends on xbvm_pkg for the payload types.
interface xbvm_req_if
   import xbvm_pkg::*;
();
   logic    valid;
   logic    ready;
   req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface xbvm_rsp_if
   import xbvm_pkg::*;
();
   logic    valid;
   logic    ready;
   rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// File: hw/rtl/xbvm_data_mem.sv
// Data memory: synchronous RAM with a registered read, write forwarding and
// per-entry valid bits that make unwritten entries read as zero after reset.
// Depends on xbvm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module xbvm_data_mem
   import xbvm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  rd_en,
   input  logic [MEM_ADDR_W-1:0] rd_addr,
   input  mem_wr_type            wr,
   output logic [BYTE_W-1:0]     rd_data
);

   logic [BYTE_W-1:0]    mem_array [MEM_DEPTH];
   logic [MEM_DEPTH-1:0] valid_ff, valid_in;
   logic [BYTE_W-1:0]    rd_data_ff;
   logic                 rd_hit_ff, rd_hit_in;
   logic                 fwd;

   assign fwd = wr.en && (wr.addr == rd_addr);

   always_comb begin
      valid_in = valid_ff;
      if (wr.en) begin
         valid_in[wr.addr] = 1'b1;
      end
   end

   always_comb begin
      rd_hit_in = rd_hit_ff;
      if (rd_en) begin
         rd_hit_in = fwd || valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_array[wr.addr] <= wr.data;
      end
   end

   // take the data being written this edge over the stale array contents
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (fwd) begin
            rd_data_ff <= wr.data;
         end else begin
            rd_data_ff <= mem_array[rd_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rd_hit_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         rd_hit_ff <= rd_hit_in;
      end
   end

   assign rd_data = rd_hit_ff ? rd_data_ff : '0;

   `XBVM_ASSERT_NEXT(a_wr_sets_valid, wr.en, valid_ff[$past(wr.addr)], "written entry not valid")

endmodule

// File: hw/rtl/xbvm_exec.sv
// Execute stage: register file, equality flag and program counter, and the
// per-opcode next-state logic. Depends on xbvm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module xbvm_exec
   import xbvm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              go,
   input  dec_type           dec,
   input  logic [BYTE_W-1:0] mem_rd_data,
   output mem_wr_type        mem_wr,
   output rsp_type           result
);

   logic [BYTE_W-1:0]   reg_file_ff [NUM_REGS];
   logic                equal_flag_ff, equal_flag_in;
   logic [PC_WIDTH-1:0] pc_ff, pc_in;

   logic [BYTE_W-1:0]    reg_a, reg_b, reg_c;
   logic                 reg_we;
   logic [REG_IDX_W-1:0] reg_wa;
   logic [BYTE_W-1:0]    reg_wd;
   logic [PC_WIDTH-1:0]  pc_jump;
   logic                 mem_we;
   logic                 pc_hold;

   assign reg_a   = reg_file_ff[reg_index(dec.a)];
   assign reg_b   = reg_file_ff[reg_index(dec.b)];
   assign reg_c   = reg_file_ff[reg_index(dec.c)];
   assign pc_jump = pc_ff + PC_WIDTH'($signed(dec.a));

   always_comb begin
      pc_in              = pc_ff;
      equal_flag_in      = equal_flag_ff;
      reg_we             = 1'b0;
      reg_wa             = reg_index(dec.a);
      reg_wd             = dec.b;
      mem_we             = 1'b0;
      mem_wr.addr        = mem_index(dec.data_addr);
      mem_wr.data        = dec.data_value;
      result.print_valid = 1'b0;
      result.print_value = '0;
      result.halted      = 1'b0;
      result.illegal_op  = 1'b0;
      if (dec.func == FUNC_MEM_WRITE) begin
         mem_we = 1'b1;
      end else begin
         unique case (dec.op)
            OP_SET: begin
               reg_we = 1'b1;
               pc_in  = pc_ff + PC_WIDTH'(3);
            end
            OP_ADD: begin
               reg_we = 1'b1;
               reg_wd = reg_b + reg_c;
               pc_in  = pc_ff + PC_WIDTH'(4);
            end
            OP_PRINT: begin
               result.print_valid = 1'b1;
               result.print_value = reg_a;
               pc_in              = pc_ff + PC_WIDTH'(2);
            end
            OP_LOAD: begin
               reg_we = 1'b1;
               reg_wd = mem_rd_data;
               pc_in  = pc_ff + PC_WIDTH'(3);
            end
            OP_STORE: begin
               mem_we      = 1'b1;
               mem_wr.addr = mem_index(dec.a);
               mem_wr.data = reg_b;
               pc_in       = pc_ff + PC_WIDTH'(3);
            end
            OP_CMP: begin
               equal_flag_in = (reg_a == reg_b);
               pc_in         = pc_ff + PC_WIDTH'(3);
            end
            OP_JMP: begin
               pc_in = pc_jump;
            end
            OP_JEQ: begin
               pc_in = equal_flag_ff ? pc_jump : pc_ff + PC_WIDTH'(2);
            end
            OP_JNE: begin
               pc_in = !equal_flag_ff ? pc_jump : pc_ff + PC_WIDTH'(2);
            end
            OP_HALT: begin
               result.halted = 1'b1;
            end
            default: begin
               result.illegal_op = 1'b1;
            end
         endcase
      end
      mem_wr.en      = go && mem_we;
      result.next_pc = BYTE_W'(pc_in);
   end

   assign pc_hold = result.halted || result.illegal_op || (dec.func == FUNC_MEM_WRITE);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            reg_file_ff[i] <= '0;
         end
         equal_flag_ff <= 1'b0;
         pc_ff         <= '0;
      end else if (go) begin
         if (reg_we) begin
            reg_file_ff[reg_wa] <= reg_wd;
         end
         equal_flag_ff <= equal_flag_in;
         pc_ff         <= pc_in;
      end
   end

   `XBVM_ASSERT_NEXT(a_pc_holds, go && pc_hold, $stable(pc_ff), "counter moved on hold")
   `XBVM_ASSERT_SAME(a_wr_needs_go, mem_wr.en, go, "memory write without execute")
   `XBVM_ASSERT_SAME(a_print_zero, !result.print_valid, result.print_value == '0, "stray print")

endmodule

// File: hw/rtl/xor_bytecode_vm_core.sv
// A transaction accepted into s1_dec_ff reaches rsp_data_ff when go fires.
// Throughput: one transaction per cycle while responses are taken; decode and
// data memory read happen at accept, execute and state update when go fires.
// Reset: synchronous; registers, flag, counter and key reset together and data
// memory valid bits clear at once, so no clearing pass is needed.
// Depends on xbvm_pkg, xbvm_chan_if, xbvm_data_mem and xbvm_exec.
module xor_bytecode_vm_core
   import xbvm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   xbvm_req_if.sink              req_ch,
   xbvm_rsp_if.source            rsp_ch,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   logic [BYTE_W-1:0] key_ff, key_in;
   logic              s1_valid_ff, s1_valid_in;
   dec_type           s1_dec_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff;

   dec_type           dec_in;
   logic              accept, go, csr_wr;
   logic [BYTE_W-1:0] mem_rd_data;
   mem_wr_type        mem_wr;
   rsp_type           exec_result;

   // configuration register
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;
   assign prdata = (paddr[2] == CSR_IDX_XOR_KEY) ? CSR_DATA_W'(key_ff) : '0;

   always_comb begin
      key_in = key_ff;
      if (csr_wr && paddr[2] == CSR_IDX_XOR_KEY) begin
         key_in = pwdata[BYTE_W-1:0];
      end
   end

   // descramble at accept
   always_comb begin
      dec_in.func       = req_ch.payload.func;
      dec_in.op         = req_ch.payload.code_byte0 ^ key_ff;
      dec_in.a          = req_ch.payload.code_byte1 ^ key_ff;
      dec_in.b          = req_ch.payload.code_byte2 ^ key_ff;
      dec_in.c          = req_ch.payload.code_byte3 ^ key_ff;
      dec_in.data_addr  = req_ch.payload.data_addr;
      dec_in.data_value = req_ch.payload.data_value;
   end

   // advance the execute stage whenever the response register frees up
   assign go           = s1_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || go;
   assign accept       = req_ch.valid && req_ch.ready;

   assign s1_valid_in  = accept ? 1'b1 : (go ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = go ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff       <= KEY_RESET;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         key_ff       <= key_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_dec_ff <= dec_in;
      end
      if (go) begin
         rsp_data_ff <= exec_result;
      end
   end

   xbvm_data_mem u_data_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (mem_index(dec_in.b)),
      .wr      (mem_wr),
      .rd_data (mem_rd_data)
   );

   xbvm_exec u_exec (
      .clock       (clock),
      .reset       (reset),
      .go          (go),
      .dec         (s1_dec_ff),
      .mem_rd_data (mem_rd_data),
      .mem_wr      (mem_wr),
      .result      (exec_result)
   );

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_data_ff;

endmodule

// File: test/xor_bytecode_vm_core_checker.sv
// Self-checking monitor for the scrambled byte-code machine core.
// Watches the request, response and CSR ports, predicts each response and compares.
// Depends on xbvm_pkg and the channel interfaces in xbvm_chan_if.
module xor_bytecode_vm_core_checker
   import xbvm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   xbvm_req_if                   req_ch,
   xbvm_rsp_if                   rsp_ch,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   input  logic [CSR_DATA_W-1:0] prdata,
   input  logic                  pready,
   output int                    fail_count,
   output int                    outstanding,
   output int                    checked_count,
   output int                    print_count,
   output int                    jump_count,
   output int                    halt_count,
   output int                    illegal_count
);

   localparam logic [CSR_ADDR_W-1:0] KEY_ADDR = CSR_ADDR_W'(CSR_IDX_XOR_KEY) << 2;

   typedef logic [PC_WIDTH-1:0] pc_type;

   // shadow copy of the machine
   logic [BYTE_W-1:0] vm_key;
   logic [BYTE_W-1:0] vm_regs [NUM_REGS];
   logic              vm_flag;
   pc_type            vm_pc;
   logic [BYTE_W-1:0] vm_mem [MEM_DEPTH];

   rsp_type expected_rsp_q[$];

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
      fail_count++;
   endtask

   task automatic reset_vm();
      vm_key  = KEY_RESET;
      vm_flag = 1'b0;
      vm_pc   = '0;
      foreach (vm_regs[i]) vm_regs[i] = '0;
      foreach (vm_mem[i]) vm_mem[i] = '0;
   endtask

   // Execute one transaction on the shadow machine and return its response.
   task automatic step_vm(input req_type t, output rsp_type r);
      logic [BYTE_W-1:0] op, a, b, c;
      pc_type npc;
      r   = '0;
      npc = vm_pc;
      if (t.func == FUNC_MEM_WRITE) begin
         vm_mem[t.data_addr % MEM_DEPTH] = t.data_value;
      end else begin
         op = t.code_byte0 ^ vm_key;
         a  = t.code_byte1 ^ vm_key;
         b  = t.code_byte2 ^ vm_key;
         c  = t.code_byte3 ^ vm_key;
         case (op) inside
            OP_SET: begin
               vm_regs[a % NUM_REGS] = b;
               npc = vm_pc + pc_type'(3);
            end
            OP_ADD: begin
               vm_regs[a % NUM_REGS] = vm_regs[b % NUM_REGS] + vm_regs[c % NUM_REGS];
               npc = vm_pc + pc_type'(4);
            end
            OP_PRINT: begin
               r.print_valid = 1'b1;
               r.print_value = vm_regs[a % NUM_REGS];
               npc = vm_pc + pc_type'(2);
               print_count++;
            end
            OP_LOAD: begin
               vm_regs[a % NUM_REGS] = vm_mem[b % MEM_DEPTH];
               npc = vm_pc + pc_type'(3);
            end
            OP_STORE: begin
               vm_mem[a % MEM_DEPTH] = vm_regs[b % NUM_REGS];
               npc = vm_pc + pc_type'(3);
            end
            OP_CMP: begin
               vm_flag = (vm_regs[a % NUM_REGS] == vm_regs[b % NUM_REGS]);
               npc = vm_pc + pc_type'(3);
            end
            OP_JMP, OP_JEQ, OP_JNE: begin
               // offset is relative to the jump itself; sign-extend to counter width
               if (op == OP_JMP || (op == OP_JEQ) == vm_flag) begin
                  npc = vm_pc + pc_type'($signed(a));
                  jump_count++;
               end else begin
                  npc = vm_pc + pc_type'(2);
               end
            end
            OP_HALT: begin
               r.halted = 1'b1;
               halt_count++;
            end
            default: begin
               r.illegal_op = 1'b1;
               illegal_count++;
            end
         endcase
      end
      vm_pc     = npc;
      r.next_pc = BYTE_W'(npc);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      if (reset) begin
         reset_vm();
         expected_rsp_q.delete();
      end else begin
         if (psel && penable && pready && paddr == KEY_ADDR) begin
            if (pwrite)
               vm_key = pwdata[BYTE_W-1:0];
            else if (prdata !== CSR_DATA_W'(vm_key))
               report_mismatch("xor_key readback", prdata, CSR_DATA_W'(vm_key));
         end
         if (req_ch.valid && req_ch.ready) begin
            step_vm(req_ch.payload, want);
            expected_rsp_q.push_back(want);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = rsp_ch.payload;
            if (expected_rsp_q.size() == 0) begin
               report_mismatch("response with none expected, next_pc", got.next_pc, '0);
            end else begin
               want = expected_rsp_q.pop_front();
               checked_count++;
               if (got.next_pc !== want.next_pc)
                  report_mismatch("next_pc", got.next_pc, want.next_pc);
               if (got.print_valid !== want.print_valid)
                  report_mismatch("print_valid", got.print_valid, want.print_valid);
               if (got.print_value !== want.print_value)
                  report_mismatch("print_value", got.print_value, want.print_value);
               if (got.halted !== want.halted)
                  report_mismatch("halted", got.halted, want.halted);
               if (got.illegal_op !== want.illegal_op)
                  report_mismatch("illegal_op", got.illegal_op, want.illegal_op);
            end
         end
      end
      outstanding <= expected_rsp_q.size();
   end

endmodule

// File: test/xor_bytecode_vm_core_tb.sv
// Top of the byte-code machine testbench: clock, reset, stimulus and verdict.
// Drives scrambled instruction streams and key changes; checking is done by
// xor_bytecode_vm_core_checker. Depends on xbvm_pkg and xbvm_chan_if.
module xor_bytecode_vm_core_tb;
   import xbvm_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] KEY_ADDR = CSR_ADDR_W'(CSR_IDX_XOR_KEY) << 2;
   localparam int IDLE_PCT     = 22;
   localparam int NUM_PHASES   = 5;
   localparam int PHASE_ITEMS  = 250;
   localparam int QUIET_FIRST  = 700;
   localparam int QUIET_LAST   = 900;
   localparam int DRAIN_LIMIT  = 5000;
   localparam int HOLD_AFTER   = 400;
   localparam int HOLD_CYCLES  = 80;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   int fail_count;
   int outstanding;
   int checked_count;
   int print_count;
   int jump_count;
   int halt_count;
   int illegal_count;

   int                items_sent = 0;
   logic [BYTE_W-1:0] code_key;

   xbvm_req_if req_ch ();
   xbvm_rsp_if rsp_ch ();

   xor_bytecode_vm_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   xor_bytecode_vm_core_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .rsp_ch        (rsp_ch),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready),
      .fail_count    (fail_count),
      .outstanding   (outstanding),
      .checked_count (checked_count),
      .print_count   (print_count),
      .jump_count    (jump_count),
      .halt_count    (halt_count),
      .illegal_count (illegal_count)
   );

   always #2 clock = ~clock;

   initial begin : watchdog
      #2000000;
      $display("xor_bytecode_vm_core verification failed");
      $finish;
   end

   function automatic logic [BYTE_W-1:0] rnd_byte();
      return BYTE_W'($urandom);
   endfunction

   // register operand with random upper bits, which the core must ignore
   function automatic logic [BYTE_W-1:0] reg_byte(input int r);
      return (rnd_byte() << REG_IDX_W) | BYTE_W'(r);
   endfunction

   function automatic req_type make_exec(input logic [BYTE_W-1:0] op, a, b, c);
      req_type t;
      t.func       = FUNC_EXECUTE;
      t.code_byte0 = op ^ code_key;
      t.code_byte1 = a ^ code_key;
      t.code_byte2 = b ^ code_key;
      t.code_byte3 = c ^ code_key;
      t.data_addr  = rnd_byte();
      t.data_value = rnd_byte();
      return t;
   endfunction

   function automatic req_type make_mem_write(input logic [BYTE_W-1:0] addr, value);
      req_type t;
      t.func       = FUNC_MEM_WRITE;
      t.code_byte0 = rnd_byte();
      t.code_byte1 = rnd_byte();
      t.code_byte2 = rnd_byte();
      t.code_byte3 = rnd_byte();
      t.data_addr  = addr;
      t.data_value = value;
      return t;
   endfunction

   function automatic req_type random_item();
      int                pick;
      logic [BYTE_W-1:0] op, a, b;
      pick = $urandom_range(0, 99);
      a    = rnd_byte();
      b    = rnd_byte();
      if (pick < 15) return make_mem_write(a, b);
      if      (pick < 30) op = OP_SET;
      else if (pick < 38) op = OP_ADD;
      else if (pick < 50) op = OP_PRINT;
      else if (pick < 60) op = OP_LOAD;
      else if (pick < 68) op = OP_STORE;
      else if (pick < 78) op = OP_CMP;
      else if (pick < 83) op = OP_JMP;
      else if (pick < 89) op = OP_JEQ;
      else if (pick < 95) op = OP_JNE;
      else if (pick < 97) op = OP_HALT;
      else begin
         do op = rnd_byte();
         while (op inside {OP_SET, OP_ADD, OP_PRINT, OP_LOAD, OP_STORE, OP_CMP,
                           OP_JMP, OP_JEQ, OP_JNE, OP_HALT});
      end
      // small values and same-register compares make equality common
      if (op == OP_SET && $urandom_range(0, 1)) b = BYTE_W'($urandom_range(0, 3));
      if (op == OP_CMP && $urandom_range(0, 2) == 0) b = a;
      return make_exec(op, a, b, rnd_byte());
   endfunction

   task automatic send_item(input req_type item);
      bit quiet;
      quiet = (items_sent >= QUIET_FIRST && items_sent < QUIET_LAST);
      while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.payload <= item;
      do @(posedge clock); while (!req_ch.ready);
      items_sent++;
   endtask

   // Drop valid and wait until all expected responses are back or the guard expires.
   task automatic drain_responses();
      int guard;
      guard = 0;
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_access(input logic write, input logic [CSR_ADDR_W-1:0] addr,
                             input logic [CSR_DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= write;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // Load a secret into data memory, then check it byte by byte as a program would.
   task automatic password_check_run();
      int                len;
      logic [BYTE_W-1:0] base;
      logic [BYTE_W-1:0] secret [8];
      logic [BYTE_W-1:0] guess;
      len  = $urandom_range(1, 8);
      base = rnd_byte();
      for (int i = 0; i < len; i++) begin
         secret[i] = rnd_byte();
         send_item(make_mem_write(base + BYTE_W'(i), secret[i]));
      end
      for (int i = 0; i < len; i++) begin
         guess = ($urandom_range(0, 3) != 0) ? secret[i] : rnd_byte();
         send_item(make_exec(OP_LOAD, reg_byte(0), base + BYTE_W'(i), rnd_byte()));
         send_item(make_exec(OP_SET, reg_byte(1), guess, rnd_byte()));
         send_item(make_exec(OP_CMP, reg_byte(0), reg_byte(1), rnd_byte()));
         send_item(make_exec($urandom_range(0, 1) ? OP_JNE : OP_JEQ,
                             rnd_byte(), rnd_byte(), rnd_byte()));
      end
      send_item(make_exec(OP_PRINT, reg_byte($urandom_range(0, NUM_REGS - 1)),
                          rnd_byte(), rnd_byte()));
      if ($urandom_range(0, 3) == 0)
         send_item(make_exec(OP_HALT, rnd_byte(), rnd_byte(), rnd_byte()));
   endtask

   task automatic run_directed();
      send_item(make_exec(OP_SET,   8'h00, 8'h7F, 8'h00));
      send_item(make_exec(OP_SET,   8'hFD, 8'h01, 8'hFF));  // index masks to r1
      send_item(make_exec(OP_ADD,   8'h02, 8'h00, 8'h01));  // 127 + 1 wraps to -128
      send_item(make_exec(OP_PRINT, 8'h02, 8'h00, 8'h00));
      send_item(make_exec(OP_PRINT, 8'hFF, 8'hFF, 8'hFF));
      send_item(make_mem_write(8'hFF, 8'h80));
      send_item(make_mem_write(8'h00, 8'hFF));
      send_item(make_exec(OP_LOAD,  8'h03, 8'hFF, 8'h00));
      send_item(make_exec(OP_STORE, 8'h10, 8'h03, 8'h00));
      send_item(make_exec(OP_LOAD,  8'h00, 8'h10, 8'h00));
      send_item(make_exec(OP_CMP,   8'h03, 8'h00, 8'h00));
      send_item(make_exec(OP_JEQ,   8'hFC, 8'h00, 8'h00));  // taken, backward
      send_item(make_exec(OP_JNE,   8'h40, 8'h00, 8'h00));  // not taken
      send_item(make_exec(OP_LOAD,  8'h01, 8'h00, 8'h00));
      send_item(make_exec(OP_CMP,   8'h01, 8'h02, 8'h00));
      send_item(make_exec(OP_JNE,   8'h7F, 8'h00, 8'h00));  // taken, largest forward
      send_item(make_exec(OP_JEQ,   8'h80, 8'h00, 8'h00));  // not taken
      send_item(make_exec(OP_JMP,   8'h80, 8'h00, 8'h00));  // largest backward
      send_item(make_exec(OP_PRINT, 8'h01, 8'h00, 8'h00));
      send_item(make_exec(OP_HALT,  8'h00, 8'h00, 8'h00));
      send_item(make_exec(OP_HALT,  8'hFF, 8'hFF, 8'hFF));
      send_item(make_exec(8'h00,    8'h00, 8'h00, 8'h00));  // unknown opcodes
      send_item(make_exec(8'h0A,    8'h01, 8'h02, 8'h03));
      send_item(make_exec(OP_ADD,   8'h02, 8'h03, 8'h03));  // -128 + -128 wraps to 0
      send_item(make_exec(OP_PRINT, 8'h02, 8'h00, 8'h00));
   endtask

   // Response side: random stalls, one long hold-off to back up the core,
   // and a stretch with ready held high.
   initial begin : rsp_drain
      int  rsp_seen;
      int  hold_left;
      bit  held;
      rsp_seen  = 0;
      hold_left = 0;
      held      = 1'b0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) rsp_seen++;
         if (rsp_seen == HOLD_AFTER && !held) begin
            hold_left = HOLD_CYCLES;
            held      = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (rsp_seen >= QUIET_FIRST && rsp_seen < QUIET_LAST) begin
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

   initial begin : stimulus
      logic [BYTE_W-1:0] new_key;
      int                phase_start;
      reset          = 1'b1;
      psel           = 1'b0;
      penable        = 1'b0;
      pwrite         = 1'b0;
      paddr          = '0;
      pwdata         = '0;
      req_ch.valid   = 1'b0;
      req_ch.payload = '0;
      code_key       = KEY_RESET;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      run_directed();

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         drain_responses();
         case (phase)
            0:              new_key = 8'h00;
            1:              new_key = 8'hFF;
            NUM_PHASES - 1: new_key = KEY_RESET;
            default:        new_key = rnd_byte();
         endcase
         csr_access(1'b1, KEY_ADDR, CSR_DATA_W'(new_key));
         csr_access(1'b0, KEY_ADDR, '0);
         code_key    = new_key;
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS) begin
            if ($urandom_range(0, 99) < 55)
               password_check_run();
            else
               send_item(random_item());
         end
      end

      drain_responses();
      if (outstanding != 0)
         $display("%0d responses never arrived", outstanding);
      $display("run covered %0d transactions under %0d key settings, %0d responses checked",
               items_sent, NUM_PHASES + 1, checked_count);
      $display("prints %0d, jumps taken %0d, halts %0d, unknown opcodes %0d",
               print_count, jump_count, halt_count, illegal_count);
      if (fail_count == 0 && outstanding == 0) begin
         $display("xor_bytecode_vm_core verification clean");
      end else begin
         $display("xor_bytecode_vm_core verification failed");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/xbvm_pkg.sv
hw/rtl/xbvm_chan_if.sv
hw/rtl/xbvm_data_mem.sv
hw/rtl/xbvm_exec.sv
hw/rtl/xor_bytecode_vm_core.sv
test/xor_bytecode_vm_core_checker.sv
test/xor_bytecode_vm_core_tb.sv
